### rtl/gsrq_pkg.sv
`default_nettype none

package gsrq_pkg;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_UP     = 3'd1,
    ACT_DOWN   = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_CANCEL = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_UP      = 2'd0,
    KIND_DOWN    = 2'd1,
    KIND_NEUTRAL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_NONE = 2'd2
  } dir_e;

  localparam logic [2:0]  GEAR_NEUTRAL  = 3'd0;
  localparam logic [2:0]  GEAR_FIRST    = 3'd1;
  localparam logic [2:0]  GEAR_SECOND   = 3'd2;
  localparam logic [2:0]  GEAR_FAILED   = 3'd7;
  localparam int unsigned TOP_GEAR      = 6;
  localparam logic [15:0] LOCKOUT_RESET = 16'd50;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [2:0] action;
    logic       neutral_held;
    logic [2:0] gear_code;
    logic [1:0] shift_kind;
  } item_t;

  typedef struct packed {
    logic [3:0] up_queued;
    logic [3:0] down_queued;
    logic       neutral_queued;
    logic [1:0] failsafe_direction;
    logic       lockout_error;
    logic       queue_report;
  } result_t;

endpackage

`default_nettype wire

### rtl/gsrq_item_if.sv
`default_nettype none

interface gsrq_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       neutral_held;
  logic [2:0] gear_code;
  logic [1:0] shift_kind;

  modport source (output valid, output action, output neutral_held, output gear_code,
                  output shift_kind, input ready);
  modport sink   (input valid, input action, input neutral_held, input gear_code,
                  input shift_kind, output ready);
endinterface

`default_nettype wire

### rtl/gsrq_result_if.sv
`default_nettype none

interface gsrq_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] up_queued;
  logic [3:0] down_queued;
  logic       neutral_queued;
  logic [1:0] failsafe_direction;
  logic       lockout_error;
  logic       queue_report;

  modport source (output valid, output up_queued, output down_queued,
                  output neutral_queued, output failsafe_direction,
                  output lockout_error, output queue_report, input ready);
  modport sink   (input valid, input up_queued, input down_queued,
                  input neutral_queued, input failsafe_direction,
                  input lockout_error, input queue_report, output ready);
endinterface

`default_nettype wire

### rtl/gsrq_in_stage.sv
`default_nettype none

module gsrq_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  gsrq_item_if.sink          req,
  input  wire logic          advance_i,
  output gsrq_pkg::item_t    item_o,
  output logic               valid_o
);
  import gsrq_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign req.ready = advance_i || !valid_q;
  assign item_o    = item_q;
  assign valid_o   = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req.ready) begin
      valid_q <= req.valid;
    end
  end

  // capture beat
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      item_q.action       <= req.action;
      item_q.neutral_held <= req.neutral_held;
      item_q.gear_code    <= req.gear_code;
      item_q.shift_kind   <= req.shift_kind;
    end
  end

endmodule

`default_nettype wire

### rtl/gsrq_core.sv
`default_nettype none

module gsrq_core #(
  parameter int unsigned MAX_QUEUE = 15
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire gsrq_pkg::item_t  item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [15:0]      cfg_data_i,
  output gsrq_pkg::result_t     res_o
);
  import gsrq_pkg::*;

  localparam int unsigned CountW = $clog2(MAX_QUEUE + 1);
  localparam int unsigned SumW   = CountW + 1;
  localparam logic [CountW-1:0] MaxQ = CountW'(MAX_QUEUE);

  logic [15:0]       lockout_q;
  logic [15:0]       ticks_q, ticks_d;
  logic [CountW-1:0] up_q, up_d;
  logic [CountW-1:0] down_q, down_d;
  logic              npend_q, npend_d;
  dir_e              dir_q, dir_d;
  logic              lock_err, report;
  logic              up_room, down_room;
  logic              gear_low;

  assign up_room   = (SumW'(up_q) + SumW'(item_i.gear_code)) < SumW'(TOP_GEAR);
  assign down_room = (SumW'(down_q) + SumW'(1)) < SumW'(item_i.gear_code);
  assign gear_low  = item_i.gear_code inside {[GEAR_FIRST:GEAR_SECOND]};

  always_comb begin
    ticks_d  = ticks_q;
    up_d     = up_q;
    down_d   = down_q;
    npend_d  = npend_q;
    dir_d    = dir_q;
    lock_err = 1'b0;
    report   = 1'b0;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (ticks_q != TICKS_MAX) ticks_d = ticks_q + 16'd1;
      end
      ACT_UP: begin
        if (!npend_q) begin
          if (ticks_q < lockout_q) begin
            lock_err = 1'b1;
          end else if (item_i.neutral_held) begin
            report  = 1'b1;
            ticks_d = '0;
            if (item_i.gear_code == GEAR_NEUTRAL) begin
              down_d = CountW'(1); up_d = '0; npend_d = 1'b0;
            end else if (gear_low) begin
              npend_d = 1'b1; up_d = '0; down_d = '0;
            end else if (item_i.gear_code == GEAR_FAILED) begin
              npend_d = 1'b1; up_d = '0; down_d = '0; dir_d = DIR_UP;
            end else begin
              down_d = CountW'(1);
            end
          end else if (item_i.gear_code == GEAR_NEUTRAL) begin
            report = 1'b1; ticks_d = '0;
            up_d = CountW'(1); down_d = '0; npend_d = 1'b0;
          end else if (down_q != '0 || npend_q) begin
            report = 1'b1;
            up_d = '0; down_d = '0; npend_d = 1'b0;
          end else if (item_i.gear_code == GEAR_FAILED || up_room) begin
            report  = 1'b1;
            ticks_d = '0;
            up_d    = (up_q < MaxQ) ? up_q + CountW'(1) : MaxQ;
          end
        end
      end
      ACT_DOWN: begin
        if (!npend_q) begin
          if (ticks_q < lockout_q) begin
            lock_err = 1'b1;
          end else if (item_i.neutral_held) begin
            report  = 1'b1;
            ticks_d = '0;
            if (item_i.gear_code == GEAR_NEUTRAL) begin
              npend_d = 1'b0;
            end else if (gear_low) begin
              npend_d = 1'b1; up_d = '0; down_d = '0;
            end else if (item_i.gear_code == GEAR_FAILED) begin
              npend_d = 1'b1; up_d = '0; down_d = '0; dir_d = DIR_DOWN;
            end else begin
              down_d = CountW'(1); up_d = '0; npend_d = 1'b0;
            end
          end else if (up_q != '0 || npend_q) begin
            report = 1'b1;
            up_d = '0; down_d = '0; npend_d = 1'b0;
          end else if (item_i.gear_code == GEAR_FAILED ||
                       item_i.gear_code == GEAR_NEUTRAL || down_room) begin
            report  = 1'b1;
            ticks_d = '0;
            down_d  = (down_q < MaxQ) ? down_q + CountW'(1) : MaxQ;
          end
        end
      end
      ACT_DONE: begin
        case (kind_e'(item_i.shift_kind))
          KIND_UP: begin
            report = 1'b1;
            if (up_q != '0) up_d = up_q - CountW'(1);
          end
          KIND_DOWN: begin
            report = 1'b1;
            if (down_q != '0) down_d = down_q - CountW'(1);
          end
          KIND_NEUTRAL: begin
            report = 1'b1; npend_d = 1'b0;
          end
          default: ;
        endcase
      end
      ACT_CANCEL: begin
        case (kind_e'(item_i.shift_kind))
          KIND_UP:      begin report = 1'b1; up_d = '0;      end
          KIND_DOWN:    begin report = 1'b1; down_d = '0;    end
          KIND_NEUTRAL: begin report = 1'b1; npend_d = 1'b0; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign res_o.up_queued          = 4'(up_d);
  assign res_o.down_queued        = 4'(down_d);
  assign res_o.neutral_queued     = npend_d;
  assign res_o.failsafe_direction = dir_d;
  assign res_o.lockout_error      = lock_err;
  assign res_o.queue_report       = report;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LOCKOUT_RESET;
      ticks_q   <= '0;
      up_q      <= '0;
      down_q    <= '0;
      npend_q   <= 1'b0;
      dir_q     <= DIR_NONE;
    end else begin
      if (cfg_we_i) lockout_q <= cfg_data_i;
      if (fire_i) begin
        ticks_q <= ticks_d;
        up_q    <= up_d;
        down_q  <= down_d;
        npend_q <= npend_d;
        dir_q   <= dir_d;
      end
    end
  end

  a_up_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_q <= MaxQ && down_q <= MaxQ)
    else $error("queue count above bound");

  a_neutral_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    npend_q |-> (up_q == '0 && down_q == '0))
    else $error("neutral pending with shifts queued");

  a_hold_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> ($stable(up_q) && $stable(down_q) && $stable(npend_q) &&
                 $stable(ticks_q) && $stable(dir_q)))
    else $error("state moved without a beat");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lock_err && report))
    else $error("lockout error with report");

endmodule

`default_nettype wire

### rtl/gear_shift_request_queue.sv
// Gear shift request queue. Takes one beat per clock on req (tick, paddle
// press, shift done or shift cancelled) while rsp is not stalled and returns
// one beat on rsp per accepted beat, in order, via the input register and
// the queue update logic into the result register. A stalled rsp holds the
// result register; the input register takes at most one more beat. The
// lockout window (cfg_data_i, written with cfg_we_i; the user must write it
// only while idle, the block does not enforce this) resets to 50 ticks;
// queue counts saturate at MAX_QUEUE and rsp carries their low four bits.
`default_nettype none

module gear_shift_request_queue #(
  parameter int unsigned MAX_QUEUE = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  gsrq_item_if.sink        req,
  gsrq_result_if.source    rsp,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i
);
  import gsrq_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  result_t res;
  result_t rsp_q;
  logic    rsp_valid_q;

  assign advance = !rsp_valid_q || rsp.ready;
  assign fire    = item_valid && advance;

  gsrq_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req),
    .advance_i (advance),
    .item_o    (item),
    .valid_o   (item_valid)
  );

  gsrq_core #(
    .MAX_QUEUE (MAX_QUEUE)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid              = rsp_valid_q;
  assign rsp.up_queued          = rsp_q.up_queued;
  assign rsp.down_queued        = rsp_q.down_queued;
  assign rsp.neutral_queued     = rsp_q.neutral_queued;
  assign rsp.failsafe_direction = rsp_q.failsafe_direction;
  assign rsp.lockout_error      = rsp_q.lockout_error;
  assign rsp.queue_report       = rsp_q.queue_report;

endmodule

`default_nettype wire

### bench/gear_shift_request_queue_tb.sv
`timescale 1ns / 100ps

module gear_shift_request_queue_tb;
  import gsrq_pkg::*;

  localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;
  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam int         MAX_QUEUE      = 15;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 4;

  typedef struct packed {
    bit          wr;
    logic [15:0] lock;
    item_t       beat;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;

  gsrq_item_if   req_if ();
  gsrq_result_if rsp_if ();

  gear_shift_request_queue u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data)
  );

  logic [15:0] lock_window;
  logic [15:0] ticks_since;
  int          up_cnt;
  int          down_cnt;
  logic        neutral_pend;
  dir_e        fs_dir;

  result_t   queued_results[$];
  plan_row_t plan[$];
  int        sent;
  int        faults;
  int        idle_cycles;
  bit        full_rate;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int saturating_inc(int v);
    return (v < MAX_QUEUE) ? v + 1 : MAX_QUEUE;
  endfunction

  function automatic bit press_up(logic held, logic [2:0] gear);
    if (held) begin
      if (gear == GEAR_NEUTRAL) begin
        down_cnt = 1; up_cnt = 0; neutral_pend = 1'b0;
      end else if (gear == GEAR_FIRST || gear == GEAR_SECOND) begin
        neutral_pend = 1'b1; up_cnt = 0; down_cnt = 0;
      end else if (gear == GEAR_FAILED) begin
        neutral_pend = 1'b1; up_cnt = 0; down_cnt = 0; fs_dir = DIR_UP;
      end else begin
        down_cnt = 1;
      end
      ticks_since = '0;
      return 1'b1;
    end
    if (gear == GEAR_NEUTRAL) begin
      up_cnt = 1; down_cnt = 0; neutral_pend = 1'b0;
      ticks_since = '0;
      return 1'b1;
    end
    if (down_cnt > 0 || neutral_pend) begin
      up_cnt = 0; down_cnt = 0; neutral_pend = 1'b0;
      return 1'b1;
    end
    if (gear == GEAR_FAILED || up_cnt + int'(gear) < int'(TOP_GEAR)) begin
      up_cnt = saturating_inc(up_cnt);
      ticks_since = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit press_down(logic held, logic [2:0] gear);
    if (held) begin
      if (gear == GEAR_NEUTRAL) begin
        neutral_pend = 1'b0;
      end else if (gear == GEAR_FIRST || gear == GEAR_SECOND) begin
        neutral_pend = 1'b1; up_cnt = 0; down_cnt = 0;
      end else if (gear == GEAR_FAILED) begin
        neutral_pend = 1'b1; up_cnt = 0; down_cnt = 0; fs_dir = DIR_DOWN;
      end else begin
        down_cnt = 1; up_cnt = 0; neutral_pend = 1'b0;
      end
      ticks_since = '0;
      return 1'b1;
    end
    if (up_cnt > 0 || neutral_pend) begin
      up_cnt = 0; down_cnt = 0; neutral_pend = 1'b0;
      return 1'b1;
    end
    if (gear == GEAR_FAILED || gear == GEAR_NEUTRAL || down_cnt + 1 < int'(gear)) begin
      down_cnt = saturating_inc(down_cnt);
      ticks_since = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t queue_step(item_t b);
    result_t r;
    logic    err;
    logic    rep;
    err = 1'b0;
    rep = 1'b0;
    case (b.action)
      ACT_TICK: begin
        if (ticks_since != TICKS_MAX) ticks_since = ticks_since + 16'd1;
      end
      ACT_UP, ACT_DOWN: begin
        if (!neutral_pend) begin
          if (ticks_since < lock_window) err = 1'b1;
          else if (b.action == ACT_UP) rep = press_up(b.neutral_held, b.gear_code);
          else rep = press_down(b.neutral_held, b.gear_code);
        end
      end
      ACT_DONE: begin
        rep = 1'b1;
        if (b.shift_kind == KIND_UP) begin
          if (up_cnt > 0) up_cnt = up_cnt - 1;
        end else if (b.shift_kind == KIND_DOWN) begin
          if (down_cnt > 0) down_cnt = down_cnt - 1;
        end else if (b.shift_kind == KIND_NEUTRAL) begin
          neutral_pend = 1'b0;
        end else begin
          rep = 1'b0;
        end
      end
      ACT_CANCEL: begin
        rep = 1'b1;
        if (b.shift_kind == KIND_UP) up_cnt = 0;
        else if (b.shift_kind == KIND_DOWN) down_cnt = 0;
        else if (b.shift_kind == KIND_NEUTRAL) neutral_pend = 1'b0;
        else rep = 1'b0;
      end
      default: begin
      end
    endcase
    r.up_queued          = up_cnt[3:0];
    r.down_queued        = down_cnt[3:0];
    r.neutral_queued     = neutral_pend;
    r.failsafe_direction = fs_dir;
    r.lockout_error      = err;
    r.queue_report       = rep;
    return r;
  endfunction

  function automatic plan_row_t row(bit wr, logic [15:0] lock, logic [2:0] act, logic held,
                                    logic [2:0] gear, logic [1:0] kind, bit typed,
                                    result_t want);
    plan_row_t p;
    p.wr                = wr;
    p.lock              = lock;
    p.beat.action       = act;
    p.beat.neutral_held = held;
    p.beat.gear_code    = gear;
    p.beat.shift_kind   = kind;
    p.typed             = typed;
    p.want              = want;
    return p;
  endfunction

  function automatic item_t rand_beat(logic [2:0] act);
    item_t b;
    b.action       = act;
    b.neutral_held = 1'($urandom_range(0, 1));
    b.gear_code    = ($urandom_range(0, 2) == 0) ? GEAR_FAILED : 3'($urandom_range(0, 7));
    b.shift_kind   = 2'($urandom_range(0, 3));
    return b;
  endfunction

  task automatic send_beat(item_t b, bit typed, result_t want);
    int      gap;
    result_t r;
    gap = full_rate ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= b.action;
    req_if.neutral_held <= b.neutral_held;
    req_if.gear_code    <= b.gear_code;
    req_if.shift_kind   <= b.shift_kind;
    do @(posedge clk); while (!req_if.ready);
    r = queue_step(b);
    queued_results.push_back(typed ? want : r);
    sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    wait (queued_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic set_lockout(logic [15:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lock_window = v;
  endtask

  task automatic run_phase(logic [15:0] lock, int count);
    int    stop;
    int    ticks;
    item_t b;
    set_lockout(lock);
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 24) == 0) full_rate = !full_rate;
      if ($urandom_range(0, 59) == 0) drain();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 9: begin
          // Send tick beats, up to around the lockout edge unless the window is large, then press.
          if (lock > 16'd1000) ticks = $urandom_range(0, 3);
          else if (lock > 16'd2) ticks = int'(lock) - 1 + $urandom_range(0, 2);
          else ticks = $urandom_range(0, int'(lock) + 1);
          if ($urandom_range(0, 9) == 9) ticks = 0;
          repeat (ticks) send_beat(rand_beat(ACT_TICK), 1'b0, '0);
          b = rand_beat($urandom_range(0, 1) ? ACT_UP : ACT_DOWN);
          b.neutral_held = ($urandom_range(0, 3) == 0);
          send_beat(b, 1'b0, '0);
        end
        6, 7: send_beat(rand_beat($urandom_range(0, 1) ? ACT_DONE : ACT_CANCEL), 1'b0, '0);
        default: send_beat(rand_beat(3'($urandom_range(0, 7))), 1'b0, '0);
      endcase
    end
  endtask

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (queued_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        faults++;
      end else begin
        exp_r = queued_results.pop_front();
        check_field("up_queued", exp_r.up_queued, rsp_if.up_queued);
        check_field("down_queued", exp_r.down_queued, rsp_if.down_queued);
        check_field("neutral_queued", exp_r.neutral_queued, rsp_if.neutral_queued);
        check_field("failsafe_direction", exp_r.failsafe_direction,
                    rsp_if.failsafe_direction);
        check_field("lockout_error", exp_r.lockout_error, rsp_if.lockout_error);
        check_field("queue_report", exp_r.queue_report, rsp_if.queue_report);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = full_rate ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_data            <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_TICK;
    req_if.neutral_held <= 1'b0;
    req_if.gear_code    <= GEAR_NEUTRAL;
    req_if.shift_kind   <= KIND_UP;
    idle_cycles         = 0;
    faults              = 0;
    sent                = 0;
    full_rate           = 1'b0;
    lock_window         = LOCKOUT_RESET;
    ticks_since         = '0;
    up_cnt              = 0;
    down_cnt            = 0;
    neutral_pend        = 1'b0;
    fs_dir              = DIR_NONE;

    plan.push_back(row(0, '0, ACT_UP, 1'b0, 3'd3, KIND_UP, 1,
                       '{4'd0, 4'd0, 1'b0, DIR_NONE, 1'b1, 1'b0}));
    plan.push_back(row(1, 16'd0, ACT_TICK, 1'b0, GEAR_NEUTRAL, KIND_UP, 1,
                       '{4'd0, 4'd0, 1'b0, DIR_NONE, 1'b0, 1'b0}));
    plan.push_back(row(0, '0, ACT_UP, 1'b1, GEAR_FAILED, KIND_UP, 1,
                       '{4'd0, 4'd0, 1'b1, DIR_UP, 1'b0, 1'b1}));
    plan.push_back(row(0, '0, ACT_DOWN, 1'b0, 3'd3, KIND_UP, 1,
                       '{4'd0, 4'd0, 1'b1, DIR_UP, 1'b0, 1'b0}));
    plan.push_back(row(0, '0, ACT_DONE, 1'b0, 3'd3, KIND_NEUTRAL, 1,
                       '{4'd0, 4'd0, 1'b0, DIR_UP, 1'b0, 1'b1}));
    plan.push_back(row(0, '0, ACT_DOWN, 1'b1, GEAR_FAILED, KIND_UP, 1,
                       '{4'd0, 4'd0, 1'b1, DIR_DOWN, 1'b0, 1'b1}));
    plan.push_back(row(0, '0, ACT_CANCEL, 1'b0, 3'd3, KIND_NEUTRAL, 1,
                       '{4'd0, 4'd0, 1'b0, DIR_DOWN, 1'b0, 1'b1}));
    plan.push_back(row(0, '0, ACT_UP, 1'b0, GEAR_FAILED, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_UP, 1'b1, 3'd4, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_UP, 1'b0, 3'd3, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_UP, 1'b0, GEAR_NEUTRAL, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_UP, 1'b0, 3'd5, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_DOWN, 1'b0, 3'd6, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_DOWN, 1'b0, 3'd6, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_DOWN, 1'b0, GEAR_SECOND, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_DOWN, 1'b1, GEAR_NEUTRAL, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_DOWN, 1'b1, 3'd5, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_UP, 1'b1, GEAR_FIRST, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_DONE, 1'b0, 3'd3, KIND_UNUSED, 0, '0));
    plan.push_back(row(0, '0, ACT_CANCEL, 1'b0, 3'd3, KIND_UNUSED, 0, '0));
    plan.push_back(row(0, '0, ACT_DONE, 1'b0, 3'd3, KIND_NEUTRAL, 0, '0));
    plan.push_back(row(0, '0, ACT_DONE, 1'b0, 3'd3, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_UNUSED_LO, 1'b0, GEAR_NEUTRAL, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_UNUSED_HI, 1'b1, GEAR_FAILED, KIND_UNUSED, 0, '0));
    plan.push_back(row(0, '0, ACT_UP, 1'b1, GEAR_NEUTRAL, KIND_UP, 0, '0));
    plan.push_back(row(0, '0, ACT_CANCEL, 1'b0, 3'd3, KIND_DOWN, 0, '0));
    plan.push_back(row(1, 16'hFFFF, ACT_DOWN, 1'b0, 3'd3, KIND_UP, 0, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].wr) set_lockout(plan[i].lock);
      send_beat(plan[i].beat, plan[i].typed, plan[i].want);
    end

    run_phase(16'd1, 110);
    run_phase(16'd0, 120);
    run_phase(16'd3, 70);
    run_phase(LOCKOUT_RESET, 90);
    run_phase(16'hFFFF, 15);
    run_phase(16'd2, 45);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
